### rtl/core/rid_pkg.sv
// ----------------------------------------------------------------------------
// rid_pkg
// Shared types and constants for the router id selector: table geometry,
// transaction payloads, table selects and id source codes.
// ----------------------------------------------------------------------------
package rid_pkg;

  // table geometry
  localparam int TableEntries = 16;
  localparam int IdxW         = (TableEntries > 1) ? $clog2(TableEntries) : 1;

  // address classification
  localparam logic [9:0] LinkLocalTop = 10'h3FA;
  localparam logic [7:0] LoopbackNet  = 8'd127;

  // id source codes
  localparam logic [2:0] SRC_NONE     = 3'd0;
  localparam logic [2:0] SRC_USER     = 3'd1;
  localparam logic [2:0] SRC_LOOPBACK = 3'd2;
  localparam logic [2:0] SRC_IPV4     = 3'd3;
  localparam logic [2:0] SRC_IPV6     = 3'd4;

  // event kinds
  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_DEL = 1'b1;

  typedef enum logic [1:0] {
    TAB_LOOP = 2'd0,
    TAB_IPV4 = 2'd1,
    TAB_IPV6 = 2'd2
  } tab_sel_t;

  // input transaction
  typedef struct packed {
    logic        kind;
    logic        is_ipv6;
    logic        loopback_interface;
    logic [31:0] address_word;
    logic [9:0]  ipv6_top_bits;
  } cmd_t;

  // result transaction
  typedef struct packed {
    logic [31:0] chosen_id;
    logic [2:0]  id_source;
    logic        add_dropped;
  } result_t;

  // sequencer to table store control
  typedef struct packed {
    tab_sel_t        tsel;
    logic [IdxW-1:0] rd_idx;
    logic            wr_en;
    logic            clr_en;
    logic [IdxW-1:0] wr_idx;
    logic [31:0]     wr_data;
  } store_ctrl_t;

  // shared compare unit results
  typedef struct packed {
    logic hit;
    logic better;
  } cmp_res_t;

endpackage

### rtl/core/router_id_selector.sv
// ----------------------------------------------------------------------------
// router_id_selector
// Tracks interface address add/delete events and selects the router id.
// ----------------------------------------------------------------------------
// Usage:
//   An event transaction is taken on a rising edge with start high and busy
//   low. Ignored addresses (IPv6 not link-local, IPv4 in 127/8) are dropped
//   at once and busy stays low. Otherwise busy rises while a small sequencer
//   walks the tables through one shared compare unit:
//     duplicate / free slot search : every entry of the selected table
//     table update                 : write or clear of one entry
//     max scan, loopback/ipv4/ipv6 : until a table holds a valid entry
//   A new event can be taken in the cycle in which done is high. A result,
//   if any, shows for one cycle with done high;
//   a delete of a key other than the current id produces none.
//   The receiver cannot stall the result.
//   The user id is written on the cfg channel (cfg_valid/cfg_ready), ready
//   whenever busy is low; it takes effect at the next selection.
//   Reset clears the valid bits of all tables, the user id and current id.
// ----------------------------------------------------------------------------
module router_id_selector (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  rid_pkg::cmd_t    cmd,
  output logic             done,
  output rid_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [31:0]      cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_FIND   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_SCAN   = 4'b1000
  } state_t;

  localparam logic [rid_pkg::IdxW-1:0] IdxLast = rid_pkg::IdxW'(rid_pkg::TableEntries - 1);

  state_t                     state;
  rid_pkg::tab_sel_t          tsel;
  logic [rid_pkg::IdxW-1:0]   idx;
  logic [31:0]                key;
  logic                       is_del;
  logic                       found;
  logic [rid_pkg::IdxW-1:0]   found_idx;
  logic                       free_any;
  logic [rid_pkg::IdxW-1:0]   free_idx;
  logic                       dropped;
  logic [31:0]                best;
  logic                       have_best;
  logic [31:0]                current_id;
  logic [31:0]                user_id;

  rid_pkg::store_ctrl_t       sctrl;
  logic [31:0]                rd_word;
  logic                       rd_valid;
  rid_pkg::cmp_res_t          cres;

  logic                       accept;
  logic                       ignored;
  logic                       drop_now;
  logic                       idx_last;
  logic                       best_any_next;
  logic [31:0]                best_next;
  logic [2:0]                 scan_src;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign idx_last  = (idx == IdxLast);

  // address filter
  always_comb begin
    if (cmd.is_ipv6) begin
      ignored = (cmd.ipv6_top_bits != rid_pkg::LinkLocalTop);
    end else begin
      ignored = (cmd.address_word[31:24] == rid_pkg::LoopbackNet);
    end
  end

  // table store
  always_comb begin
    sctrl.tsel    = tsel;
    sctrl.rd_idx  = idx;
    sctrl.wr_en   = (state == ST_UPDATE) && !is_del && !found && free_any;
    sctrl.clr_en  = (state == ST_UPDATE) && is_del && found;
    sctrl.wr_idx  = is_del ? found_idx : free_idx;
    sctrl.wr_data = key;
  end

  rid_store u_store (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (sctrl),
    .rd_word  (rd_word),
    .rd_valid (rd_valid)
  );

  // shared compare unit: key in the search, running max in the scan
  rid_cmp u_cmp (
    .entry_valid (rd_valid),
    .entry_word  (rd_word),
    .operand     ((state == ST_FIND) ? key : best),
    .have_best   (have_best),
    .res         (cres)
  );

  assign drop_now      = !is_del && !found && !free_any;
  assign best_any_next = have_best || cres.better;
  assign best_next     = cres.better ? rd_word : best;

  // source code of the table being scanned
  always_comb begin
    case (tsel)
      rid_pkg::TAB_LOOP: scan_src = rid_pkg::SRC_LOOPBACK;
      rid_pkg::TAB_IPV4: scan_src = rid_pkg::SRC_IPV4;
      rid_pkg::TAB_IPV6: scan_src = rid_pkg::SRC_IPV6;
      default:           scan_src = rid_pkg::SRC_NONE;
    endcase
  end

  // user id register
  always_ff @(posedge clk) begin
    if (rst) begin
      user_id <= '0;
    end else if (cfg_valid && cfg_ready) begin
      user_id <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      current_id <= '0;
      tsel       <= rid_pkg::TAB_LOOP;
      idx        <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept && !ignored) begin
            state    <= ST_FIND;
            idx      <= '0;
            key      <= cmd.address_word;
            is_del   <= (cmd.kind == rid_pkg::KIND_DEL);
            found    <= 1'b0;
            free_any <= 1'b0;
            if (cmd.is_ipv6) begin
              tsel <= rid_pkg::TAB_IPV6;
            end else if (cmd.loopback_interface) begin
              tsel <= rid_pkg::TAB_LOOP;
            end else begin
              tsel <= rid_pkg::TAB_IPV4;
            end
          end
        end
        // duplicate search and first free slot
        ST_FIND: begin
          if (cres.hit && !found) begin
            found     <= 1'b1;
            found_idx <= idx;
          end
          if (!rd_valid && !free_any) begin
            free_any <= 1'b1;
            free_idx <= idx;
          end
          if (idx_last) begin
            state <= ST_UPDATE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        // table write or clear, then decide whether to select
        ST_UPDATE: begin
          dropped <= drop_now;
          if (is_del && (key != current_id)) begin
            state <= ST_IDLE;
          end else if (user_id != '0) begin
            state              <= ST_IDLE;
            done               <= 1'b1;
            current_id         <= user_id;
            result.chosen_id   <= user_id;
            result.id_source   <= rid_pkg::SRC_USER;
            result.add_dropped <= drop_now;
          end else begin
            state     <= ST_SCAN;
            tsel      <= rid_pkg::TAB_LOOP;
            idx       <= '0;
            have_best <= 1'b0;
          end
        end
        // running max over loopback, ipv4, ipv6 in priority order
        ST_SCAN: begin
          best      <= best_next;
          have_best <= best_any_next;
          if (idx_last) begin
            idx <= '0;
            if (best_any_next) begin
              state              <= ST_IDLE;
              done               <= 1'b1;
              current_id         <= best_next;
              result.chosen_id   <= best_next;
              result.id_source   <= scan_src;
              result.add_dropped <= dropped;
            end else if (tsel == rid_pkg::TAB_IPV6) begin
              state              <= ST_IDLE;
              done               <= 1'b1;
              current_id         <= '0;
              result.chosen_id   <= '0;
              result.id_source   <= rid_pkg::SRC_NONE;
              result.add_dropped <= dropped;
            end else begin
              tsel      <= (tsel == rid_pkg::TAB_LOOP) ? rid_pkg::TAB_IPV4 : rid_pkg::TAB_IPV6;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/rid_store.sv
// ----------------------------------------------------------------------------
// rid_store
// The three address tables (loopback, ipv4, ipv6 link-local) with their
// valid bits; one entry read and one entry written or cleared per cycle.
// ----------------------------------------------------------------------------
module rid_store (
  input  logic                clk,
  input  logic                rst,
  input  rid_pkg::store_ctrl_t ctrl,
  output logic [31:0]         rd_word,
  output logic                rd_valid
);

  logic [31:0] loop_word  [rid_pkg::TableEntries];
  logic [31:0] ipv4_word  [rid_pkg::TableEntries];
  logic [31:0] ipv6_word  [rid_pkg::TableEntries];
  logic [rid_pkg::TableEntries-1:0] loop_valid;
  logic [rid_pkg::TableEntries-1:0] ipv4_valid;
  logic [rid_pkg::TableEntries-1:0] ipv6_valid;

  // word storage, no reset
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      case (ctrl.tsel)
        rid_pkg::TAB_LOOP: loop_word[ctrl.wr_idx] <= ctrl.wr_data;
        rid_pkg::TAB_IPV4: ipv4_word[ctrl.wr_idx] <= ctrl.wr_data;
        rid_pkg::TAB_IPV6: ipv6_word[ctrl.wr_idx] <= ctrl.wr_data;
        default: ;
      endcase
    end
  end

  // valid bits, set on write and cleared on delete
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_valid <= '0;
      ipv4_valid <= '0;
      ipv6_valid <= '0;
    end else if (ctrl.wr_en || ctrl.clr_en) begin
      case (ctrl.tsel)
        rid_pkg::TAB_LOOP: loop_valid[ctrl.wr_idx] <= ctrl.wr_en;
        rid_pkg::TAB_IPV4: ipv4_valid[ctrl.wr_idx] <= ctrl.wr_en;
        rid_pkg::TAB_IPV6: ipv6_valid[ctrl.wr_idx] <= ctrl.wr_en;
        default: ;
      endcase
    end
  end

  // read port of the selected table
  always_comb begin
    case (ctrl.tsel)
      rid_pkg::TAB_LOOP: begin
        rd_word  = loop_word[ctrl.rd_idx];
        rd_valid = loop_valid[ctrl.rd_idx];
      end
      rid_pkg::TAB_IPV4: begin
        rd_word  = ipv4_word[ctrl.rd_idx];
        rd_valid = ipv4_valid[ctrl.rd_idx];
      end
      rid_pkg::TAB_IPV6: begin
        rd_word  = ipv6_word[ctrl.rd_idx];
        rd_valid = ipv6_valid[ctrl.rd_idx];
      end
      default: begin
        rd_word  = '0;
        rd_valid = 1'b0;
      end
    endcase
  end

endmodule

### rtl/core/rid_cmp.sv
// ----------------------------------------------------------------------------
// rid_cmp
// Shared 32-bit compare unit: key match for the duplicate search and
// running-maximum test for the id scan.
// ----------------------------------------------------------------------------
module rid_cmp (
  input  logic              entry_valid,
  input  logic [31:0]       entry_word,
  input  logic [31:0]       operand,
  input  logic              have_best,
  output rid_pkg::cmp_res_t res
);

  // equal for the search, greater (or first valid) for the scan
  always_comb begin
    res.hit    = entry_valid && (entry_word == operand);
    res.better = entry_valid && (!have_best || (entry_word > operand));
  end

endmodule

### rtl/core/rid_checker.sv
// ----------------------------------------------------------------------------
// rid_checker
// Port-level checks on the router id selector: result strobe timing against
// busy and consistency of the result fields.
// ----------------------------------------------------------------------------
module rid_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input rid_pkg::result_t result
);

  // busy only rises after a start
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

  // a result only follows a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without preceding busy period");

  // the block is free again while the result shows
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy still high with result strobe");

  // no back-to-back result strobes
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // no source means a zero id
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.id_source == rid_pkg::SRC_NONE)) |-> (result.chosen_id == '0))
    else $error("nonzero router id with no source");

endmodule

bind router_id_selector rid_checker u_rid_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
